### hdl/sliding_window_trend_stats_core_macros.svh
`ifndef SLIDING_WINDOW_TREND_STATS_CORE_MACROS_SVH
`define SLIDING_WINDOW_TREND_STATS_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SWTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swts assertion failed");

// next-cycle implication, checked outside reset
`define SWTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swts assertion failed");

`endif

### hdl/swts_pkg.sv
package swts_pkg;

  localparam int RING_DEPTH = 32;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int SAMPLE_W   = 24;
  localparam int SEEN_W     = $clog2(RING_DEPTH + 2);
  localparam int PCT_SCALE  = 100;
  localparam int WIDE_W     = 56;
  localparam int DSR_W      = 25;
  localparam int STEP_W     = 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_MUL_PS2,
    S_MUL_A1,
    S_AVG_GO,
    S_AVG_RUN,
    S_PCT_GO,
    S_PCT_RUN,
    S_VAR_GO,
    S_VAR_RUN,
    S_SQ_GO,
    S_SQ_RUN,
    S_DONE
  } state_t;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } iter_op_t;

  typedef struct packed {
    logic              start;
    iter_op_t          op;
    logic [STEP_W-1:0] steps;
  } iter_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;

endpackage

### hdl/sliding_window_trend_stats_core.sv
// Flow: an accepted sample starts a walk of the ring, then the multiply states S_MUL_PS2
// and S_MUL_A1, then 29 + 33 + 56 divider steps and 28 square-root
// steps in one shared unit, each run framed by a start cycle and a done cycle.
// No new sample is accepted until the previous result is parked; the output
// register frees the input side as soon as a result is parked. Reset (rst_n, synchronous,
// active low) empties the window, sets the trend rising, zeroes the switch count, period 1.
module sliding_window_trend_stats_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [23:0] in_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_avg_increase,
  output logic        out_avg_valid,
  output logic signed [15:0] out_percent_change,
  output logic [22:0] out_std_dev,
  output logic        out_std_valid,
  output logic        out_switch_seen,
  output logic [15:0] out_switch_total
);
  import swts_pkg::*;

  localparam int SUM_W = SAMPLE_W + RING_AW;
  localparam int SQ_W  = 2 * SAMPLE_W - 1;
  localparam int S2_W  = SQ_W + RING_AW;
  localparam int NUM_W = 33;

  state_t state_r, state_nxt;

  logic [RING_AW-1:0]  period_r, p;
  logic [RING_AW-1:0]  head_r, hd_r;
  logic [SEEN_W-1:0]   seen_r;
  logic                rising_r;
  logic [15:0]         swcnt_r;

  logic [SAMPLE_W-1:0] ring [RING_DEPTH];
  logic [SAMPLE_W-1:0] rdata_r;
  logic [RING_AW-1:0]  rd_addr;
  logic [SEEN_W-1:0]   cnt_r;
  logic                rd_v_r, sq_v_r;
  logic [RING_AW-1:0]  rk_r;

  logic signed [SAMPLE_W-1:0] x, prev_r, cur_r, old_r;
  logic signed [SAMPLE_W:0]   diff;
  logic [SUM_W-1:0]           sum_r;
  logic signed [SUM_W-1:0]    s1_r;
  logic [SQ_W-1:0]            sq_r;
  logic [S2_W-1:0]            s2_r;
  logic [WIDE_W-1:0]          ps2_r, a1sq_r;
  logic [SUM_W-2:0]           a1;
  logic                       avg_ok, std_ok, sw_r;

  logic signed [SAMPLE_W:0] co;
  logic [SAMPLE_W:0]        an0;
  logic [SAMPLE_W-1:0]      ad;
  logic [NUM_W-1:0]         pnum;
  logic                     pneg;

  logic [23:0] avg_r;
  logic signed [15:0] pct_r;
  logic [22:0] std_r;

  iter_ctl_t         ictl;
  iter_sts_t         ists;
  logic [WIDE_W-1:0] idvd, ires;
  logic [DSR_W-1:0]  idsr;

  assign p       = (period_r == '0) ? RING_AW'(1) : period_r;
  assign avg_ok  = seen_r > SEEN_W'(p);
  assign std_ok  = seen_r >= SEEN_W'(p);
  assign rd_addr = hd_r - cnt_r[RING_AW-1:0];
  assign x       = rdata_r;
  assign diff    = {prev_r[SAMPLE_W-1], prev_r} - {x[SAMPLE_W-1], x};
  assign a1      = s1_r[SUM_W-1] ? (SUM_W-1)'(-s1_r) : s1_r[SUM_W-2:0];

  assign co   = {cur_r[SAMPLE_W-1], cur_r} - {old_r[SAMPLE_W-1], old_r};
  assign an0  = co[SAMPLE_W] ? (SAMPLE_W+1)'(-co) : co;
  assign ad   = old_r[SAMPLE_W-1] ? SAMPLE_W'(-old_r) : old_r;
  assign pnum = {(NUM_W-1)'(an0) * (NUM_W-1)'(PCT_SCALE), 1'b0} + NUM_W'(ad);
  assign pneg = co[SAMPLE_W] != old_r[SAMPLE_W-1];

  swts_iter u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ictl),
    .dvd    (idvd),
    .dsr    (idsr),
    .sts    (ists),
    .result (ires)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_WALK;
      S_WALK:    if (cnt_r == SEEN_W'(p) + SEEN_W'(1)) state_nxt = S_MUL_PS2;
      S_MUL_PS2: state_nxt = S_MUL_A1;
      S_MUL_A1:  state_nxt = S_AVG_GO;
      S_AVG_GO:  state_nxt = S_AVG_RUN;
      S_AVG_RUN: if (ists.done) state_nxt = S_PCT_GO;
      S_PCT_GO:  state_nxt = S_PCT_RUN;
      S_PCT_RUN: if (ists.done) state_nxt = S_VAR_GO;
      S_VAR_GO:  state_nxt = S_VAR_RUN;
      S_VAR_RUN: if (ists.done) state_nxt = S_SQ_GO;
      S_SQ_GO:   state_nxt = S_SQ_RUN;
      S_SQ_RUN:  if (ists.done) state_nxt = S_DONE;
      S_DONE:    if (!out_valid || out_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs toward the shared unit and the input side
  always_comb begin
    in_ready   = (state_r == S_IDLE);
    ictl.start = 1'b0;
    ictl.op    = OP_DIV;
    ictl.steps = '0;
    idvd       = '0;
    idsr       = '0;
    case (state_r)
      S_AVG_GO: begin
        ictl.start = 1'b1;
        ictl.steps = STEP_W'(SUM_W);
        idvd       = {sum_r, (WIDE_W-SUM_W)'(0)};
        idsr       = DSR_W'(p);
      end
      S_PCT_GO: begin
        ictl.start = 1'b1;
        ictl.steps = STEP_W'(NUM_W);
        idvd       = {pnum, (WIDE_W-NUM_W)'(0)};
        idsr       = {ad, 1'b0};
      end
      S_VAR_GO: begin
        ictl.start = 1'b1;
        ictl.steps = STEP_W'(WIDE_W);
        idvd       = ps2_r - a1sq_r;
        idsr       = DSR_W'(p * p);
      end
      S_SQ_GO: begin
        ictl.start = 1'b1;
        ictl.op    = OP_SQRT;
        ictl.steps = STEP_W'(WIDE_W / 2);
        idvd       = ires;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // ring: write on accept, registered read during the walk
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) ring[head_r] <= in_sample;
    rdata_r <= ring[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= RING_AW'(1);
      head_r    <= '0;
      seen_r    <= '0;
      rising_r  <= 1'b1;
      swcnt_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) period_r <= cfg_wdata;
      if (in_valid && in_ready) begin
        head_r <= head_r + 1'b1;
        if (seen_r < SEEN_W'(RING_DEPTH + 1)) seen_r <= seen_r + 1'b1;
      end
      if (state_r == S_MUL_PS2 && avg_ok) begin
        if (old_r == '0) begin
          if (cur_r > 0) rising_r <= 1'b1;
          else if (cur_r < 0) rising_r <= 1'b0;
        end else if (co != '0) begin
          rising_r <= !pneg;
        end
      end
      // sw_r holds this transaction's switch from here on
      if (state_r == S_MUL_A1 && sw_r && swcnt_r != 16'hFFFF) swcnt_r <= swcnt_r + 1'b1;
      if (state_r == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rd_v_r <= (state_r == S_WALK) && (cnt_r <= SEEN_W'(p));
    sq_v_r <= (state_r == S_WALK) && rd_v_r && (rk_r < p);
    if (state_r == S_IDLE) s2_r <= '0;
    else if (sq_v_r) s2_r <= s2_r + S2_W'(sq_r);
    case (state_r)
      S_IDLE: begin
        hd_r  <= head_r;
        cnt_r <= '0;
        sum_r <= '0;
        s1_r  <= '0;
      end
      S_WALK: begin
        cnt_r  <= cnt_r + 1'b1;
        rk_r   <= cnt_r[RING_AW-1:0];
        if (rd_v_r) begin
          prev_r <= x;
          if (rk_r != '0 && diff > 0) sum_r <= sum_r + SUM_W'(diff[SAMPLE_W-1:0]);
          if (rk_r == '0) cur_r <= x;
          if (rk_r == p)  old_r <= x;
          if (rk_r < p) begin
            s1_r <= s1_r + SUM_W'(x);
            sq_r <= SQ_W'(x * x);
          end
        end
      end
      S_MUL_PS2: begin
        ps2_r <= WIDE_W'(s2_r * p);
        // a switch needs more than period+1 samples and a reversed direction
        sw_r  <= (seen_r > SEEN_W'(p) + SEEN_W'(1)) &&
                 ((old_r == '0) ?
                  ((rising_r && cur_r < 0) || (!rising_r && cur_r > 0)) :
                  ((co != '0) && ((rising_r && pneg) || (!rising_r && !pneg))));
      end
      S_MUL_A1: a1sq_r <= WIDE_W'(a1 * a1);
      S_AVG_RUN: begin
        if (ists.done) begin
          if (!avg_ok) avg_r <= '0;
          else if (ires[WIDE_W-1:24] != '0) avg_r <= 24'hFFFFFF;
          else avg_r <= ires[23:0];
        end
      end
      S_PCT_RUN: begin
        if (ists.done) begin
          if (!avg_ok) pct_r <= '0;
          else if (old_r == '0)
            pct_r <= (cur_r > 0) ? 16'sh7FFF : ((cur_r < 0) ? 16'sh8000 : 16'sh0000);
          else if (pneg)
            pct_r <= (ires[NUM_W-1:15] != '0) ? 16'sh8000 : 16'(-ires[15:0]);
          else
            pct_r <= (ires[NUM_W-1:15] != '0) ? 16'sh7FFF : ires[15:0];
        end
      end
      S_SQ_RUN: begin
        if (ists.done) begin
          if (!std_ok) std_r <= '0;
          else if (ires[WIDE_W-1:23] != '0) std_r <= 23'h7FFFFF;
          else std_r <= ires[22:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid || out_ready)) begin
      out_avg_increase   <= avg_r;
      out_avg_valid      <= avg_ok;
      out_percent_change <= pct_r;
      out_std_dev        <= std_r;
      out_std_valid      <= std_ok;
      out_switch_seen    <= sw_r && avg_ok;
      out_switch_total   <= swcnt_r;
    end
  end

`include "sliding_window_trend_stats_core_macros.svh"

  `SWTS_ASSERT_NOW(a_idle_unit, in_ready, !ists.busy)
  `SWTS_ASSERT_NOW(a_avg_std, out_valid && out_avg_valid, out_std_valid)
  `SWTS_ASSERT_NOW(a_sw_avg, out_valid && out_switch_seen, out_avg_valid)
  `SWTS_ASSERT_NEXT(a_accept_walk, in_valid && in_ready, state_r == S_WALK)

endmodule

### hdl/swts_iter.sv
module swts_iter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  swts_pkg::iter_ctl_t         ctl,
  input  logic [swts_pkg::WIDE_W-1:0] dvd,
  input  logic [swts_pkg::DSR_W-1:0]  dsr,
  output swts_pkg::iter_sts_t         sts,
  output logic [swts_pkg::WIDE_W-1:0] result
);
  import swts_pkg::*;

  iter_op_t          op_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [WIDE_W-1:0] acc_r, acc_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt, dsr_r;
  logic [WIDE_W-1:0] res_r, res_nxt, bit_r;
  logic [DSR_W:0]    trial;
  logic [WIDE_W:0]   rb;

  // one restoring-division bit or one square-root digit per step
  always_comb begin
    trial   = {rem_r, acc_r[WIDE_W-1]};
    rb      = {1'b0, res_r} + {1'b0, bit_r};
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    res_nxt = res_r;
    case (op_r)
      OP_DIV: begin
        if (trial >= {1'b0, dsr_r}) begin
          rem_nxt = DSR_W'(trial - {1'b0, dsr_r});
          acc_nxt = {acc_r[WIDE_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DSR_W-1:0];
          acc_nxt = {acc_r[WIDE_W-2:0], 1'b0};
        end
      end
      OP_SQRT: begin
        if ({1'b0, acc_r} >= rb) begin
          acc_nxt = WIDE_W'({1'b0, acc_r} - rb);
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !ctl.start && busy_r && (cnt_r == STEP_W'(1));
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op_r  <= ctl.op;
      acc_r <= dvd;
      dsr_r <= dsr;
      rem_r <= '0;
      res_r <= '0;
      bit_r <= WIDE_W'(1) << (WIDE_W - 2);
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = (op_r == OP_DIV) ? acc_r : res_r;

endmodule

### tb/sliding_window_trend_stats_checker.sv
module sliding_window_trend_stats_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [23:0] in_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [23:0]        out_avg_increase,
  input  logic               out_avg_valid,
  input  logic signed [15:0] out_percent_change,
  input  logic [22:0]        out_std_dev,
  input  logic               out_std_valid,
  input  logic               out_switch_seen,
  input  logic [15:0]        out_switch_total,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [23:0]        avg_increase;
    logic               avg_valid;
    logic signed [15:0] percent_change;
    logic [22:0]        std_dev;
    logic               std_valid;
    logic               switch_seen;
    logic [15:0]        switch_total;
  } trend_result_t;

  localparam int DEPTH = swts_pkg::RING_DEPTH;

  logic signed [23:0] hist [DEPTH];
  int unsigned   head;
  int unsigned   seen;
  bit            rising;
  int unsigned   switches;
  logic [4:0]    period_reg;
  trend_result_t result_q[$];

  function automatic longint past(int unsigned k);
    return longint'(hist[(head + DEPTH - 1 - (k % DEPTH)) % DEPTH]);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  task automatic predict_trend(logic signed [23:0] smp);
    int unsigned p, k;
    longint cur, old, num, d, s1, x, pct;
    longint unsigned sum, avg, an, ad, q, s2, a1, var_v, stdv, ax;
    int dir;
    bit sw, neg;
    trend_result_t r;
    p = period_reg;
    if (p < 1) p = 1;
    if (p > DEPTH - 1) p = DEPTH - 1;
    hist[head] = smp;
    head = (head + 1) % DEPTH;
    if (seen < DEPTH + 1) seen++;
    avg = 0; pct = 0; dir = 0; sw = 0; stdv = 0;
    if (seen > p) begin
      cur = past(0);
      old = past(p);
      sum = 0;
      for (k = 0; k < p; k++) begin
        d = past(k) - past(k + 1);
        if (d > 0) sum += d;
      end
      avg = sum / p;
      if (avg > 24'hFFFFFF) avg = 24'hFFFFFF;
      num = (cur - old) * 100;
      if (old == 0) begin
        pct = cur > 0 ? 32767 : (cur < 0 ? -32768 : 0);
        dir = cur > 0 ? 1 : (cur < 0 ? -1 : 0);
      end else begin
        an = num < 0 ? -num : num;
        ad = old < 0 ? -old : old;
        q = (2 * an + ad) / (2 * ad);
        neg = (num < 0) != (old < 0);
        if (q > 32768) q = 32768;
        pct = neg ? -longint'(q) : longint'(q);
        if (pct > 32767) pct = 32767;
        dir = (num == 0) ? 0 : (neg ? -1 : 1);
      end
      if (seen > p + 1) sw = (!rising && dir > 0) || (rising && dir < 0);
      if (dir > 0) rising = 1;
      else if (dir < 0) rising = 0;
      if (sw && switches < 16'hFFFF) switches++;
    end
    if (seen >= p) begin
      s1 = 0; s2 = 0;
      for (k = 0; k < p; k++) begin
        x = past(k);
        ax = x < 0 ? -x : x;
        s1 += x;
        s2 += ax * ax;
      end
      a1 = s1 < 0 ? -s1 : s1;
      var_v = (longint'(p) * s2 - a1 * a1) / (longint'(p) * p);
      stdv = root_floor(var_v);
      if (stdv > 23'h7FFFFF) stdv = 23'h7FFFFF;
    end
    r.avg_increase   = avg[23:0];
    r.avg_valid      = seen > p;
    r.percent_change = pct[15:0];
    r.std_dev        = stdv[22:0];
    r.std_valid      = seen >= p;
    r.switch_seen    = sw;
    r.switch_total   = switches[15:0];
    result_q.insert(result_q.size(), r);
  endtask

  always @(posedge clk) begin
    trend_result_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      head = 0;
      seen = 0;
      rising = 1;
      switches = 0;
      period_reg = 5'd1;
      fail_count <= 0;
      result_q.delete();
    end else begin
      if (cfg_we) period_reg = cfg_wdata;
      if (in_valid && in_ready) predict_trend(in_sample);
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result transaction");
          errs++;
        end else begin
          e = result_q.pop_front();
          if (e.avg_increase !== out_avg_increase) begin
            $error("avg_increase exp %0d got %0d", e.avg_increase, out_avg_increase);
            errs++;
          end
          if (e.avg_valid !== out_avg_valid) begin
            $error("avg_valid exp %0d got %0d", e.avg_valid, out_avg_valid);
            errs++;
          end
          if (e.percent_change !== out_percent_change) begin
            $error("percent_change exp %0d got %0d", e.percent_change, out_percent_change);
            errs++;
          end
          if (e.std_dev !== out_std_dev) begin
            $error("std_dev exp %0d got %0d", e.std_dev, out_std_dev);
            errs++;
          end
          if (e.std_valid !== out_std_valid) begin
            $error("std_valid exp %0d got %0d", e.std_valid, out_std_valid);
            errs++;
          end
          if (e.switch_seen !== out_switch_seen) begin
            $error("switch_seen exp %0d got %0d", e.switch_seen, out_switch_seen);
            errs++;
          end
          if (e.switch_total !== out_switch_total) begin
            $error("switch_total exp %0d got %0d", e.switch_total, out_switch_total);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= result_q.size();
  end
endmodule

### tb/tb_sliding_window_trend_stats_core.sv
module tb_sliding_window_trend_stats_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_we = 0;
  logic [4:0]         cfg_wdata = '0;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [23:0] in_sample = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [23:0]        out_avg_increase;
  logic               out_avg_valid;
  logic signed [15:0] out_percent_change;
  logic [22:0]        out_std_dev;
  logic               out_std_valid;
  logic               out_switch_seen;
  logic [15:0]        out_switch_total;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  bit                 calm = 0;

  always #10 clk = ~clk;

  sliding_window_trend_stats_core dut (.*);

  sliding_window_trend_stats_checker chk (.*);

  // result side backpressure
  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_sample(logic signed [23:0] v);
    while (!calm && $urandom_range(99) < 8) @(negedge clk);
    in_valid  <= 1;
    in_sample <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 0;
    // drop valid between transactions
    @(negedge clk);
  endtask

  task automatic drain_then_set(logic [4:0] p);
    while (pending != 0) @(negedge clk);
    repeat (220) @(negedge clk);
    cfg_we    <= 1;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic signed [23:0] pick_sample(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed(24'($urandom_range(400))) - 200);
      2: return ($urandom_range(1)) ? 24'sh7FFFFF : -24'sh800000;
      default: return $urandom_range(1) ? 24'sd0 : 24'($urandom_range(4000));
    endcase
  endfunction

  initial begin
    int unsigned periods [6] = '{0, 1, 31, 2, 7, 17};
    int mode;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: extremes, zero divisor, flat run, reversals
    send_sample(24'sh7FFFFF);
    send_sample(-24'sh800000);
    send_sample(24'sd0);
    send_sample(24'sd100);
    send_sample(24'sd0);
    send_sample(-24'sd50);
    send_sample(24'sd0);
    send_sample(24'sd0);
    send_sample(24'sd1);
    send_sample(-24'sd1);
    send_sample(24'sd2);
    send_sample(24'sd2);
    send_sample(24'sh7FFFFF);
    send_sample(24'sd1);
    send_sample(-24'sh800000);
    send_sample(-24'sd1);
    drain_then_set(5'd31);
    repeat (8) send_sample(pick_sample(2));
    for (int ph = 0; ph < 6; ph++) begin
      drain_then_set(5'(periods[ph]));
      calm = (ph == 3);
      for (int i = 0; i < 190; i++) begin
        mode = $urandom_range(3);
        send_sample(pick_sample(mode));
        if (i == 95) begin
          // hold off until the pipe is empty
          while (pending != 0) @(negedge clk);
        end
      end
      calm = 0;
    end
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

### sim.f
+incdir+hdl
hdl/swts_pkg.sv
hdl/swts_iter.sv
hdl/sliding_window_trend_stats_core.sv
tb/sliding_window_trend_stats_checker.sv
tb/tb_sliding_window_trend_stats_core.sv
